### src/ndroi_pkg.sv
// ndroi_pkg: shared widths, codes, item types and helpers for the
// N-dimensional ROI address generator. No dependencies.
package ndroi_pkg;

    // Geometry
    localparam int NUM_DIMS   = 4;
    localparam int PORT_DIMS  = 4;
    localparam int COORD_BITS = 12;
    localparam int POS_W      = COORD_BITS + 1;
    localparam int ADDR_W     = 49;
    localparam int CFG_W      = NUM_DIMS * COORD_BITS;
    localparam int SLOT_W     = 2;
    localparam int ORDER_W    = PORT_DIMS * SLOT_W;
    localparam int DIM_W      = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(27);

    // Command codes
    typedef enum logic [2:0] {
        OP_FWD   = 3'd0,
        OP_BACK  = 3'd1,
        OP_BEGIN = 3'd2,
        OP_END   = 3'd3,
        OP_JUMP  = 3'd4
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZES    = 2'd0,
        CFG_ROI_LOW  = 2'd1,
        CFG_ROI_HIGH = 2'd2,
        CFG_ORDER    = 2'd3
    } cfg_idx_t;

    typedef logic [NUM_DIMS-1:0][POS_W-1:0]      coord_vec_t;
    typedef logic [NUM_DIMS-1:0][COORD_BITS-1:0] bound_vec_t;

    // One item moving down the address chain
    typedef struct packed {
        logic [ADDR_W-1:0] acc;
        coord_vec_t        coords;
        logic              at_end;
        logic              at_begin;
    } item_t;

    // Per-dimension field of a packed config register
    function automatic logic [COORD_BITS-1:0] get_field(
        input logic [CFG_W-1:0] r,
        input int unsigned      d
    );
        get_field = r[d*COORD_BITS +: COORD_BITS];
    endfunction

    // Dimension named by an order slot; out-of-range names map to the last dim
    function automatic logic [DIM_W-1:0] slot_dim(
        input logic [ORDER_W-1:0] order,
        input int unsigned        s
    );
        logic [SLOT_W-1:0] raw;
        raw = order[s*SLOT_W +: SLOT_W];
        if (int'(raw) >= NUM_DIMS)
            slot_dim = DIM_W'(NUM_DIMS - 1);
        else
            slot_dim = DIM_W'(raw);
    endfunction

endpackage

### src/ndroi_cell.sv
// ndroi_cell: one Horner cell of the address chain, acc = acc * mult + addend.
// Elastic stage with its own valid; depends on ndroi_pkg.
module ndroi_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ndroi_pkg::item_t                in_item,
    input  logic [ndroi_pkg::POS_W-1:0]     mult,
    input  logic [ndroi_pkg::POS_W-1:0]     addend,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ndroi_pkg::item_t                out_item
);

    logic                                              valid_reg;
    ndroi_pkg::item_t                                  item_reg;
    ndroi_pkg::item_t                                  item_next;
    logic [ndroi_pkg::ADDR_W+ndroi_pkg::POS_W-1:0]     prod;

    // Stage can take an item when empty or draining this cycle
    assign in_ready = !valid_reg || out_ready;

    // One multiply-add per cell, address kept modulo 2^ADDR_W
    always_comb
    begin
        prod      = in_item.acc * mult;
        item_next = in_item;
        item_next.acc = prod[ndroi_pkg::ADDR_W-1:0] + ndroi_pkg::ADDR_W'(addend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### src/ndroi_ctrl.sv
// ndroi_ctrl: config registers, ROI bounds, coordinate state and the slot
// carry chain that applies one command per cycle while out_ready holds. Depends on ndroi_pkg.
module ndroi_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  ndroi_pkg::cfg_idx_t               cfg_index,
    input  logic [ndroi_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ndroi_pkg::op_t                    op,
    input  ndroi_pkg::bound_vec_t             target,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ndroi_pkg::item_t                  out_item,
    output logic [ndroi_pkg::CFG_W-1:0]       sizes
);

    // Config registers
    logic [ndroi_pkg::CFG_W-1:0]   sizes_reg, sizes_next;
    logic [ndroi_pkg::CFG_W-1:0]   roi_low_reg, roi_low_next;
    logic [ndroi_pkg::CFG_W-1:0]   roi_high_reg, roi_high_next;
    logic [ndroi_pkg::ORDER_W-1:0] order_reg, order_next;

    // Position state
    ndroi_pkg::coord_vec_t         coords_reg, coords_next;
    logic                          at_end_reg, at_end_next;

    // Output stage
    logic                          valid_reg;
    ndroi_pkg::item_t              item_reg;

    ndroi_pkg::bound_vec_t         lo, hi;
    logic                          accept;
    logic                          begin_now;
    logic                          begin_next;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Register write decode
    always_comb
    begin
        sizes_next    = sizes_reg;
        roi_low_next  = roi_low_reg;
        roi_high_next = roi_high_reg;
        order_next    = order_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                ndroi_pkg::CFG_SIZES:    sizes_next    = cfg_data;
                ndroi_pkg::CFG_ROI_LOW:  roi_low_next  = cfg_data;
                ndroi_pkg::CFG_ROI_HIGH: roi_high_next = cfg_data;
                ndroi_pkg::CFG_ORDER:    order_next    = cfg_data[ndroi_pkg::ORDER_W-1:0];
            endcase
        end
    end

    // ROI bounds clamped to the extent; empty range collapses to low bound
    always_comb
    begin
        for (int d = 0; d < ndroi_pkg::NUM_DIMS; d++)
        begin
            logic [ndroi_pkg::COORD_BITS-1:0] top, l, h;
            top = ndroi_pkg::get_field(sizes_next, d);
            l   = ndroi_pkg::get_field(roi_low_next, d);
            h   = ndroi_pkg::get_field(roi_high_next, d);
            if (l > top) l = top;
            if (h > top) h = top;
            if (h < l)   h = l;
            lo[d] = l;
            hi[d] = h;
        end
    end

    // Current position is the first ROI element
    always_comb
    begin
        begin_now = !at_end_reg;
        for (int d = 0; d < ndroi_pkg::NUM_DIMS; d++)
        begin
            if (coords_reg[d] != {1'b0, lo[d]}) begin_now = 1'b0;
        end
    end

    // Command apply, or reset to the ROI start on a config write: carry walks slots from fastest to slowest
    always_comb
    begin
        logic [ndroi_pkg::DIM_W-1:0] d;
        logic                        run;
        coords_next = coords_reg;
        at_end_next = at_end_reg;
        run         = 1'b1;
        d           = '0;
        if (cfg_write)
        begin
            for (int k = 0; k < ndroi_pkg::NUM_DIMS; k++)
                coords_next[k] = {1'b0, lo[k]};
            at_end_next = 1'b0;
        end
        else if (accept)
        begin
            unique case (op)
                ndroi_pkg::OP_FWD:
                begin
                    if (!at_end_reg)
                    begin
                        for (int s = 0; s < ndroi_pkg::NUM_DIMS; s++)
                        begin
                            d = ndroi_pkg::slot_dim(order_reg, s);
                            if (run)
                            begin
                                if (coords_next[d] < {1'b0, hi[d]})
                                begin
                                    coords_next[d] = coords_next[d] + ndroi_pkg::POS_W'(1);
                                    run = 1'b0;
                                end
                                else if (s != ndroi_pkg::NUM_DIMS - 1)
                                begin
                                    coords_next[d] = {1'b0, lo[d]};
                                end
                                else
                                begin
                                    coords_next[d] = {1'b0, hi[d]} + ndroi_pkg::POS_W'(1);
                                    at_end_next    = 1'b1;
                                end
                            end
                        end
                    end
                end
                ndroi_pkg::OP_BACK:
                begin
                    if (!begin_now)
                    begin
                        at_end_next = 1'b0;
                        for (int s = 0; s < ndroi_pkg::NUM_DIMS; s++)
                        begin
                            d = ndroi_pkg::slot_dim(order_reg, s);
                            if (run)
                            begin
                                if (coords_next[d] > {1'b0, lo[d]})
                                begin
                                    coords_next[d] = coords_next[d] - ndroi_pkg::POS_W'(1);
                                    run = 1'b0;
                                end
                                else if (s != ndroi_pkg::NUM_DIMS - 1)
                                begin
                                    coords_next[d] = {1'b0, hi[d]};
                                end
                            end
                        end
                    end
                end
                ndroi_pkg::OP_BEGIN:
                begin
                    for (int k = 0; k < ndroi_pkg::NUM_DIMS; k++)
                        coords_next[k] = {1'b0, lo[k]};
                    at_end_next = 1'b0;
                end
                ndroi_pkg::OP_END:
                begin
                    for (int k = 0; k < ndroi_pkg::NUM_DIMS; k++)
                        coords_next[k] = {1'b0, lo[k]};
                    d = ndroi_pkg::slot_dim(order_reg, ndroi_pkg::NUM_DIMS - 1);
                    coords_next[d] = {1'b0, hi[d]} + ndroi_pkg::POS_W'(1);
                    at_end_next    = 1'b1;
                end
                ndroi_pkg::OP_JUMP:
                begin
                    // Clamp each target into the ROI
                    for (int k = 0; k < ndroi_pkg::NUM_DIMS; k++)
                    begin
                        if (target[k] < lo[k])
                            coords_next[k] = {1'b0, lo[k]};
                        else if (target[k] > hi[k])
                            coords_next[k] = {1'b0, hi[k]};
                        else
                            coords_next[k] = {1'b0, target[k]};
                    end
                    at_end_next = 1'b0;
                end
                default:
                begin
                    coords_next = coords_reg;
                end
            endcase
        end
    end

    // Begin flag of the new position
    always_comb
    begin
        begin_next = !at_end_next;
        for (int k = 0; k < ndroi_pkg::NUM_DIMS; k++)
        begin
            if (coords_next[k] != {1'b0, lo[k]}) begin_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizes_reg    <= '0;
            roi_low_reg  <= '0;
            roi_high_reg <= '0;
            order_reg    <= ndroi_pkg::ORDER_RESET;
            coords_reg   <= '0;
            at_end_reg   <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            sizes_reg    <= sizes_next;
            roi_low_reg  <= roi_low_next;
            roi_high_reg <= roi_high_next;
            order_reg    <= order_next;
            coords_reg   <= coords_next;
            at_end_reg   <= at_end_next;
            if (in_ready)
                valid_reg <= in_valid;
        end
    end

    // First cell of the chain: address accumulator starts at coordinate zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.acc      <= ndroi_pkg::ADDR_W'(coords_next[0]);
            item_reg.coords   <= coords_next;
            item_reg.at_end   <= at_end_next;
            item_reg.at_begin <= begin_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign sizes     = sizes_reg;

endmodule

### src/nd_roi_address_generator.sv
// A result passes the coordinate stage, which loads at the edge that accepts its item,
// then one Horner cell per dimension after the first.
// Throughput: one item per cycle while out_ready holds; the coordinate update is a combinational carry
// over the order slots and the address is built by a chain of multiply-add cells.
// Reset: coordinates zero, bounds zero, order 3,2,1,0, pipeline empty.
// Top level; depends on ndroi_pkg, ndroi_ctrl and ndroi_cell.
module nd_roi_address_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ndroi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ndroi_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          operation,
    input  logic [ndroi_pkg::COORD_BITS-1:0]    target_coord_0,
    input  logic [ndroi_pkg::COORD_BITS-1:0]    target_coord_1,
    input  logic [ndroi_pkg::COORD_BITS-1:0]    target_coord_2,
    input  logic [ndroi_pkg::COORD_BITS-1:0]    target_coord_3,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ndroi_pkg::ADDR_W-1:0]        linear_address,
    output logic [ndroi_pkg::POS_W-1:0]         coord_0,
    output logic [ndroi_pkg::POS_W-1:0]         coord_1,
    output logic [ndroi_pkg::POS_W-1:0]         coord_2,
    output logic [ndroi_pkg::POS_W-1:0]         coord_3,
    output logic                                at_end,
    output logic                                at_begin
);

    logic [ndroi_pkg::PORT_DIMS-1:0][ndroi_pkg::COORD_BITS-1:0] target_all;
    logic [ndroi_pkg::PORT_DIMS-1:0][ndroi_pkg::POS_W-1:0]      coord_all;
    ndroi_pkg::bound_vec_t                                      target;
    logic [ndroi_pkg::CFG_W-1:0]                                sizes;

    ndroi_pkg::item_t stage_item  [ndroi_pkg::NUM_DIMS];
    logic             stage_valid [ndroi_pkg::NUM_DIMS];
    logic             stage_ready [ndroi_pkg::NUM_DIMS];

    assign target_all = {target_coord_3, target_coord_2, target_coord_1, target_coord_0};

    // Targets of the dimensions present
    for (genvar d = 0; d < ndroi_pkg::NUM_DIMS; d++)
    begin : g_target
        assign target[d] = target_all[d];
    end

    // Coordinate state and command logic
    ndroi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (ndroi_pkg::cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (ndroi_pkg::op_t'(operation)),
        .target    (target),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_item  (stage_item[0]),
        .sizes     (sizes)
    );

    // Horner chain: cell k folds in dimension k
    for (genvar k = 1; k < ndroi_pkg::NUM_DIMS; k++)
    begin : g_cell
        logic [ndroi_pkg::POS_W-1:0] mult;
        assign mult = {1'b0, ndroi_pkg::get_field(sizes, k)} + ndroi_pkg::POS_W'(1);

        ndroi_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k-1]),
            .in_ready  (stage_ready[k-1]),
            .in_item   (stage_item[k-1]),
            .mult      (mult),
            .addend    (stage_item[k-1].coords[k]),
            .out_valid (stage_valid[k]),
            .out_ready (stage_ready[k]),
            .out_item  (stage_item[k])
        );
    end

    assign stage_ready[ndroi_pkg::NUM_DIMS-1] = out_ready;

    // Result fields; absent dimensions read zero
    for (genvar d = 0; d < ndroi_pkg::PORT_DIMS; d++)
    begin : g_coord
        if (d < ndroi_pkg::NUM_DIMS)
        begin : g_on
            assign coord_all[d] = stage_item[ndroi_pkg::NUM_DIMS-1].coords[d];
        end
        else
        begin : g_off
            assign coord_all[d] = '0;
        end
    end

    assign out_valid      = stage_valid[ndroi_pkg::NUM_DIMS-1];
    assign linear_address = stage_item[ndroi_pkg::NUM_DIMS-1].acc;
    assign at_end         = stage_item[ndroi_pkg::NUM_DIMS-1].at_end;
    assign at_begin       = stage_item[ndroi_pkg::NUM_DIMS-1].at_begin;
    assign coord_0        = coord_all[0];
    assign coord_1        = coord_all[1];
    assign coord_2        = coord_all[2];
    assign coord_3        = coord_all[3];

    // A position cannot be both first element and one past the last
    a_end_begin_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(at_end && at_begin))
        else $error("at_end and at_begin both set");

    // With the output register empty the whole chain drains, so input is open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A begin command leaves the end flag clear in the first cell
    a_begin_clears_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !cfg_write && operation == ndroi_pkg::OP_BEGIN)
        |=> (stage_item[0].at_begin && !stage_item[0].at_end))
        else $error("go-begin did not land on the first element");

endmodule
